>>> rtl/bbm_pkg.sv
package bbm_pkg;

  localparam int CFG_W          = 11;
  localparam int COORD_W        = 10;
  localparam int CFG_IDX_W      = 1;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd1024;

  typedef struct packed {
    logic command;
    logic walkable;
  } bbm_in_t;

  typedef struct packed {
    logic               is_edge;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               last_of_run;
  } bbm_out_t;

endpackage

>>> rtl/binary_boundary_marker_3x3.sv
// Channel | Direction | Word              | Accepted when
// in      | input     | bbm_in_t          | in_valid && in_ready
// out     | output    | bbm_out_t         | out_valid && out_ready
// cfg     | input     | cfg_index/cfg_data| cfg_valid && cfg_ready (always ready)
//
// One pixel per cycle unless the output stalls; an end-of-row pixel past column 0 and
// row 0 yields two words, holding the next pixel while the two-entry buffer drains.
// Pixel stage registers the pixel and its line store read; results load when it fires.
// Reset (rst, synchronous) clears counters, window, pipeline and buffer; registers
// return to 1024. Line store is not cleared. A stalled output holds in_ready low
// once the buffer cannot take a full row-end pair.
module binary_boundary_marker_3x3 #(
  parameter int MAX_WIDTH  = bbm_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bbm_pkg::DEF_MAX_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bbm_pkg::bbm_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output bbm_pkg::bbm_out_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bbm_pkg::CFG_W-1:0]   cfg_data
);

  import bbm_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 1);
  localparam int CWW = (WW > CFG_W) ? WW : CFG_W;
  localparam int CHW = (RW > CFG_W) ? RW : CFG_W;

  // configuration
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp dimensions to 1..MAX
  logic [CWW-1:0] fw_ext, w_clamp;
  logic [CHW-1:0] fh_ext, h_clamp;
  logic [WW-1:0]  w;
  logic [RW-1:0]  h;

  assign fw_ext = CWW'(frame_width);
  assign fh_ext = CHW'(frame_height);

  always_comb begin
    if (fw_ext == '0) begin
      w_clamp = CWW'(1);
    end else if (fw_ext > CWW'(MAX_WIDTH)) begin
      w_clamp = CWW'(MAX_WIDTH);
    end else begin
      w_clamp = fw_ext;
    end
    if (fh_ext == '0) begin
      h_clamp = CHW'(1);
    end else if (fh_ext > CHW'(MAX_HEIGHT)) begin
      h_clamp = CHW'(MAX_HEIGHT);
    end else begin
      h_clamp = fh_ext;
    end
  end

  assign w = w_clamp[WW-1:0];
  assign h = h_clamp[RW-1:0];

  // input side: raster counters
  logic [XW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic          in_fire;
  logic          flush_row;
  logic          in_bit;
  logic          in_last;

  assign in_fire   = in_valid && in_ready;
  assign flush_row = (row_count >= h);
  assign in_bit    = (!flush_row && !in_data.command) ? in_data.walkable : 1'b0;
  assign in_last   = (WW'(column_count) >= (w - WW'(1)));

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (in_last) begin
      column_count_next = '0;
      row_count_next    = flush_row ? '0 : row_count + RW'(1);
    end else begin
      column_count_next = column_count + XW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_fire) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // pixel stage
  logic          s1_valid;
  logic          s1_bit;
  logic [XW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          s1_last;
  logic          s1_fwd;
  logic [1:0]    s1_fwd_data;
  logic [1:0]    rd_data;
  logic          s1_top, s1_mid;
  logic          s1_fire;

  // line store word: [1] = row y-2, [0] = row y-1
  logic [1:0] line_mem [MAX_WIDTH];

  assign s1_top = s1_fwd ? s1_fwd_data[1] : rd_data[1];
  assign s1_mid = s1_fwd ? s1_fwd_data[0] : rd_data[0];

  assign in_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rd_data <= line_mem[column_count];
    end
    if (s1_fire) begin
      line_mem[s1_col] <= {s1_mid, s1_bit};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bit      <= in_bit;
      s1_col      <= column_count;
      s1_row      <= row_count;
      s1_last     <= in_last;
      // bypass the word being written this same edge
      s1_fwd      <= s1_fire && (s1_col == column_count);
      s1_fwd_data <= {s1_mid, s1_bit};
    end
  end

  // window and judging
  logic [8:0]    window_bits, window_next;
  logic [RW-1:0] py;
  logic [XW-1:0] px_a;
  logic          edge_a, edge_b;
  logic          has_a, has_b;

  assign window_next = {s1_bit, s1_mid, s1_top, window_bits[8:3]};
  assign py          = s1_row - RW'(1);
  assign px_a        = s1_col - XW'(1);
  assign has_a       = (s1_row != '0) && (s1_col != '0);
  assign has_b       = (s1_row != '0) && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_bits <= '0;
    end else if (s1_fire) begin
      window_bits <= window_next;
    end
  end

  bbm_judge #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_judge_a (
    .left    (window_next[2:0]),
    .center  (window_next[5:3]),
    .right   (window_next[8:6]),
    .px      (px_a),
    .py      (py),
    .w       (w),
    .h       (h),
    .is_edge (edge_a)
  );

  bbm_judge #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_judge_b (
    .left    (window_next[5:3]),
    .center  (window_next[8:6]),
    .right   (3'b000),
    .px      (s1_col),
    .py      (py),
    .w       (w),
    .h       (h),
    .is_edge (edge_b)
  );

  bbm_out_t res_a, res_b;

  always_comb begin
    res_a.is_edge     = edge_a;
    res_a.out_x       = COORD_W'(px_a);
    res_a.out_y       = COORD_W'(py);
    res_a.last_of_run = !has_b;
    res_b.is_edge     = edge_b;
    res_b.out_x       = COORD_W'(s1_col);
    res_b.out_y       = COORD_W'(py);
    res_b.last_of_run = 1'b1;
  end

  // result buffer, two words deep
  bbm_out_t   out0, out1;
  logic [1:0] out_count;
  logic       pop;

  assign pop       = out_valid && out_ready;
  assign s1_fire   = s1_valid && ((out_count == 2'd0) || ((out_count == 2'd1) && pop));
  assign out_valid = (out_count != 2'd0);
  assign out_data  = out0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_count <= 2'd0;
    end else if (s1_fire) begin
      out_count <= {1'b0, has_a} + {1'b0, has_b};
    end else if (pop) begin
      out_count <= out_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out0 <= has_a ? res_a : res_b;
      out1 <= res_b;
    end else if (pop) begin
      out0 <= out1;
    end
  end

endmodule

>>> rtl/bbm_judge.sv
module bbm_judge #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic [2:0]                         left,
  input  logic [2:0]                         center,
  input  logic [2:0]                         right,
  input  logic [$clog2(MAX_WIDTH)-1:0]       px,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    py,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    h,
  output logic                               is_edge
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0] px_ext;
  logic [WW-1:0] w_last;
  logic [RW-1:0] h_last;
  logic          lv, cv, rv, uv, mv, dv;
  logic          on_border;
  logic          any_walk;

  assign px_ext = WW'(px);
  assign w_last = w - WW'(1);
  assign h_last = h - RW'(1);

  // in-frame masks for the neighbor columns and rows; the frame may have
  // shrunk under a row in progress, so test both ends
  assign lv = (px_ext != '0) && (px_ext <= w);
  assign cv = (px_ext < w);
  assign rv = (px_ext < w_last);
  assign uv = (py != '0) && (py <= h);
  assign mv = (py < h);
  assign dv = (py < h_last);

  assign on_border = (px_ext == '0) || (py == '0) || (px_ext == w_last) || (py == h_last);

  assign any_walk = (lv & ((left[0] & uv) | (left[1] & mv) | (left[2] & dv)))
                  | (cv & ((center[0] & uv) | (center[2] & dv)))
                  | (rv & ((right[0] & uv) | (right[1] & mv) | (right[2] & dv)));

  // bit 1 of a column is the middle row, the pixel being judged
  assign is_edge = center[1] ? on_border : any_walk;

endmodule

>>> tb/tb_binary_boundary_marker_3x3.sv
module tb_binary_boundary_marker_3x3;
  import bbm_pkg::*;

  localparam int MAX_W           = DEF_MAX_WIDTH;
  localparam int MAX_H           = DEF_MAX_HEIGHT;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int RANDOM_PIXELS   = 400;
  localparam int CYCLE_LIMIT     = 500000;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef enum logic {ROW_CFG, ROW_PIXEL} row_kind_e;
  typedef enum int {FILL_HALF, FILL_OPEN, FILL_WALLS, FILL_SPARSE, FILL_DENSE, FILL_NOISE}
    fill_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic             cmd;
    logic             walk;
    logic             known;    // marks typed in below, otherwise predicted
    logic [1:0]       n_marks;
    bbm_out_t         m0;
    bbm_out_t         m1;
  } script_row_t;

  localparam bbm_out_t NO_MARK = '0;
  localparam int SCRIPT_LEN = 25;

  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    // 2x2 frame: walkable corner, flush tick inside the image, pixel in the flush row
    '{ROW_CFG,   11'd2, 11'd2, CMD_PIXEL, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b1, 1'b1, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b0, 1'b1, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_FLUSH, 1'b1, 1'b1, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b1, 1'b1, 2'd2,
      '{1'b1, 10'd0, 10'd0, 1'b0}, '{1'b1, 10'd1, 10'd0, 1'b1}},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b1, 1'b1, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_FLUSH, 1'b0, 1'b1, 2'd2,
      '{1'b1, 10'd0, 10'd1, 1'b0}, '{1'b1, 10'd1, 10'd1, 1'b1}},
    // zero width acts as a single column: one word per row after the first
    '{ROW_CFG,   11'd0, 11'd3, CMD_PIXEL, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b1, 1'b1, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b0, 1'b1, 2'd1,
      '{1'b1, 10'd0, 10'd0, 1'b1}, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b0, 1'b1, 2'd1,
      '{1'b1, 10'd0, 10'd1, 1'b1}, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_FLUSH, 1'b1, 1'b1, 2'd1,
      '{1'b0, 10'd0, 10'd2, 1'b1}, NO_MARK},
    // 3x3 frame with a walkable interior pixel
    '{ROW_CFG,   11'd3, 11'd3, CMD_PIXEL, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b1, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_PIXEL, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_FLUSH, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_FLUSH, 1'b1, 1'b0, 2'd0, NO_MARK, NO_MARK},
    '{ROW_PIXEL, 11'd0, 11'd0, CMD_FLUSH, 1'b0, 1'b0, 2'd0, NO_MARK, NO_MARK}
  };

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  bbm_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  bbm_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;

  binary_boundary_marker_3x3 DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Edge-mark predictor state
  bit               older_row  [MAX_W];
  bit               recent_row [MAX_W];
  logic [8:0]       nbhd       = '0;
  int unsigned      col_at     = 0;
  int unsigned      row_at     = 0;
  logic [CFG_W-1:0] width_reg  = FRAME_WIDTH_RST;
  logic [CFG_W-1:0] height_reg = FRAME_HEIGHT_RST;

  bbm_out_t    marks_due [$];
  int          mismatches  = 0;
  int unsigned pixels_fed  = 0;
  int unsigned cycles      = 0;
  bit          idling_on   = 1'b1;
  bit          hold_off_due = 1'b0;

  function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  // Mark for the pixel in window column cc, middle row.
  function automatic logic mark_of(logic [8:0] nb, int cc, int px, int py, int w, int h);
    int dr, dc, nx, ny, wc;
    if (nb[cc*3+1]) return (px == 0 || py == 0 || px == w - 1 || py == h - 1);
    for (dr = -1; dr <= 1; dr++) begin
      for (dc = -1; dc <= 1; dc++) begin
        nx = px + dc;
        ny = py + dr;
        wc = cc + dc;
        if ((dr != 0 || dc != 0) && nx >= 0 && ny >= 0 && nx < w && ny < h &&
            wc >= 0 && wc <= 2) begin
          if (nb[wc*3+1+dr]) return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  task automatic advance_marker(input bbm_in_t px, output int n, output bbm_out_t mk0,
                                output bbm_out_t mk1);
    int unsigned w, h, c;
    logic in_flush, b, row_end;
    bbm_out_t mk [2];
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    c = (col_at >= MAX_W) ? 0 : col_at;
    in_flush = row_at >= h;
    b = (!in_flush && px.command == CMD_PIXEL) ? px.walkable : 1'b0;
    nbhd = {b, recent_row[c], older_row[c], nbhd[8:3]};
    older_row[c] = recent_row[c];
    recent_row[c] = b;
    row_end = c >= w - 1;
    n = 0;
    mk[0] = NO_MARK;
    mk[1] = NO_MARK;
    if (row_at >= 1) begin
      if (c >= 1) begin
        mk[n] = '{mark_of(nbhd, 1, c - 1, row_at - 1, w, h), COORD_W'(c - 1),
                  COORD_W'(row_at - 1), 1'b0};
        n++;
      end
      if (row_end) begin
        mk[n] = '{mark_of(nbhd, 2, c, row_at - 1, w, h), COORD_W'(c),
                  COORD_W'(row_at - 1), 1'b0};
        n++;
      end
      if (n > 0) mk[n-1].last_of_run = 1'b1;
    end
    if (row_end) begin
      col_at = 0;
      row_at = (row_at >= h) ? 0 : row_at + 1;
    end else begin
      col_at = c + 1;
    end
    mk0 = mk[0];
    mk1 = mk[1];
  endtask

  task automatic flag_error(input string msg);
    $display("ERROR @%0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int want,
                               input bbm_out_t ref_word);
    if (got != want)
      flag_error($sformatf("pixel (%0d,%0d): %s got %0d, want %0d",
                           ref_word.out_x, ref_word.out_y, name, got, want));
  endtask

  // Offer one pixel, then queue the marks it releases.
  task automatic feed(input bbm_in_t px, input logic known, input int kn,
                      input bbm_out_t k0, input bbm_out_t k1);
    int gap, n;
    bbm_out_t p0, p1;
    gap = idling_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_marker(px, n, p0, p1);
    if (known) begin
      n  = kn;
      p0 = k0;
      p1 = k1;
    end
    if (n > 0) marks_due.push_back(p0);
    if (n > 1) marks_due.push_back(p1);
    pixels_fed++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (marks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    width_reg = w;
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    height_reg = h;
    cfg_valid <= 1'b0;
  endtask

  // One full frame at the current size, flush row included.
  task automatic run_frame(input fill_e fill);
    int unsigned w, h, r, c;
    logic odd;
    bbm_in_t px;
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    for (r = 0; r <= h; r++) begin
      for (c = 0; c < w; c++) begin
        odd = ($urandom_range(0, 15) == 0);
        if (fill == FILL_NOISE) px.command = $urandom_range(0, 1);
        else if (r < h) px.command = odd ? CMD_FLUSH : CMD_PIXEL;
        else px.command = odd ? CMD_PIXEL : CMD_FLUSH;
        case (fill)
          FILL_OPEN:   px.walkable = 1'b1;
          FILL_WALLS:  px.walkable = 1'b0;
          FILL_SPARSE: px.walkable = ($urandom_range(0, 7) == 0);
          FILL_DENSE:  px.walkable = ($urandom_range(0, 7) != 0);
          default:     px.walkable = $urandom_range(0, 1);
        endcase
        feed(px, 1'b0, 0, NO_MARK, NO_MARK);
      end
    end
  endtask

  // Result side: random back-pressure, one long hold-off on request.
  initial begin : result_sink
    int stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_due) begin
        stall = HOLD_OFF_CYCLES;
        hold_off_due = 1'b0;
      end else begin
        stall = idling_on ? $urandom_range(0, 3) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_words
    bbm_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (marks_due.size() == 0) begin
        flag_error($sformatf("unexpected word for pixel (%0d,%0d)",
                             out_data.out_x, out_data.out_y));
      end else begin
        want = marks_due.pop_front();
        compare_field("is_edge", out_data.is_edge, want.is_edge, want);
        compare_field("out_x", out_data.out_x, want.out_x, want);
        compare_field("out_y", out_data.out_y, want.out_y, want);
        compare_field("last_of_run", out_data.last_of_run, want.last_of_run, want);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int frame_no;
    int unsigned start;
    bbm_in_t px;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < SCRIPT_LEN; i++) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        set_frame(SCRIPT[i].width, SCRIPT[i].height);
      end else begin
        px.command  = SCRIPT[i].cmd;
        px.walkable = SCRIPT[i].walk;
        feed(px, SCRIPT[i].known, SCRIPT[i].n_marks, SCRIPT[i].m0, SCRIPT[i].m1);
      end
    end

    start = pixels_fed;
    frame_no = 0;
    while (pixels_fed - start < RANDOM_PIXELS) begin
      idling_on = ($urandom_range(0, 4) != 0);
      if (frame_no == 2) begin
        // stall the result side while pixels keep coming
        idling_on = 1'b0;
        set_frame(11'd16, 11'd4);
        hold_off_due = 1'b1;
        run_frame(FILL_HALF);
      end else begin
        set_frame(CFG_W'($urandom_range(1, 12)), CFG_W'($urandom_range(1, 8)));
        repeat ($urandom_range(1, 2)) run_frame(fill_e'($urandom_range(0, 5)));
      end
      frame_no++;
    end

    // size extremes, zero values clamp to one
    idling_on = 1'b1;
    set_frame(11'd0, 11'd0);
    run_frame(FILL_HALF);
    set_frame(11'd6, 11'd0);
    run_frame(FILL_DENSE);
    set_frame(11'd0, 11'd5);
    run_frame(FILL_SPARSE);

    quiesce();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
